/* design/dvrt_pkg.sv */
// package: shared constants, types and codes for the route table
`timescale 1ns / 1ps
`default_nettype none
package dvrt_pkg;
	localparam int unsigned DEPTH_DEF = 32;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned COST_W = 16;
	localparam int unsigned ENTRY_W = ADDR_W + COST_W;
	localparam logic [COST_W-1:0] LIMIT_RST = 16'd301;
	localparam logic [COST_W-1:0] NOROUTE_RST = 16'd400;
	localparam logic [COST_W-1:0] COST_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		KIND_OWN = 2'd0,
		KIND_LEARN = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_DUMP = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_INSERTED = 2'd1,
		ST_LOWERED = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	localparam logic [7:0] REG_LIMIT = 8'd0;
	localparam logic [7:0] REG_NOROUTE = 8'd1;

	typedef struct packed {
		logic [1:0] kind;
		logic [ADDR_W-1:0] dest_address;
		logic [COST_W-1:0] advertised_cost;
		logic [COST_W-1:0] link_cost;
	} in_word_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [COST_W-1:0] cost;
		logic found;
		logic [1:0] status;
		logic last;
	} out_word_t;

	typedef struct packed {
		logic [7:0] index;
		logic [COST_W-1:0] data;
	} cfg_word_t;
endpackage
`default_nettype wire

/* design/dvrt_if.sv */
// interfaces: valid/ready channels for items, results and register writes
`timescale 1ns / 1ps
`default_nettype none
interface dvrt_in_if;
	import dvrt_pkg::*;
	logic valid;
	logic ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dvrt_out_if;
	import dvrt_pkg::*;
	logic valid;
	logic ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dvrt_cfg_if;
	import dvrt_pkg::*;
	logic valid;
	logic ready;
	cfg_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/dvrt_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module dvrt_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* design/dvrt_ctrl.sv */
// sequencer: scans the sorted table in ram, inserts by shifting, dumps
`timescale 1ns / 1ps
`default_nettype none
module dvrt_ctrl #(
	parameter int unsigned TABLE_DEPTH = dvrt_pkg::DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire dvrt_pkg::in_word_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output dvrt_pkg::out_word_t out_data,
	input wire logic [dvrt_pkg::COST_W-1:0] limit,
	input wire logic [dvrt_pkg::COST_W-1:0] noroute
);
	import dvrt_pkg::*;
	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_SHIFT = 6'b000100,
		S_DUMP = 6'b001000,
		S_OUT = 6'b010000,
		S_PUT = 6'b100000
	} state_t;

	state_t state_q;
	in_word_t item_q;
	logic [COST_W-1:0] sum_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	logic out_valid_q;
	out_word_t out_q;

	logic we;
	logic [IW-1:0] waddr;
	logic [ENTRY_W-1:0] wdata;
	logic [IW-1:0] raddr;
	logic [ENTRY_W-1:0] rdata;
	logic [ADDR_W-1:0] r_addr;
	logic [COST_W-1:0] r_cost;
	logic [COST_W:0] sum_w;
	logic [CW-1:0] prev_idx;
	logic [CW-1:0] back_idx;
	logic [CW-1:0] tail_idx;
	logic below_w;
	logic hit_w;
	logic ins_w;
	logic out_load;

	dvrt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign r_addr = rdata[ENTRY_W-1:COST_W];
	assign r_cost = rdata[COST_W-1:0];
	assign sum_w = {1'b0, in_data.advertised_cost} + {1'b0, in_data.link_cost};
	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// scan decisions on entry idx_q-1
	assign prev_idx = idx_q - CW'(1);
	assign back_idx = idx_q - CW'(2);
	assign tail_idx = count_q - CW'(1);
	assign below_w = prev_idx < count_q && r_addr < item_q.dest_address;
	assign hit_w = prev_idx < count_q && r_addr == item_q.dest_address;
	assign ins_w = !below_w && !hit_w && item_q.kind != KIND_QUERY && count_q != FULL;
	assign out_load = (state_q == S_OUT || state_q == S_DUMP) && (!out_valid_q || out_ready);

	// read address: scan walks forward, shift walks back from the tail
	always_comb begin
		raddr = idx_q[IW-1:0];
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					raddr = '0;
				end
			end
			S_SCAN: begin
				if (ins_w) begin
					raddr = tail_idx[IW-1:0];
				end
			end
			S_SHIFT: begin
				raddr = back_idx[IW-1:0];
			end
			S_DUMP: begin
				// hold the current entry while the result stalls
				if (!out_load) begin
					raddr = prev_idx[IW-1:0];
				end
			end
			default: raddr = idx_q[IW-1:0];
		endcase
	end

	// ram write in shift and final placement
	always_comb begin
		we = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = rdata;
		if (state_q == S_SHIFT && idx_q != pos_q) begin
			we = 1'b1;
		end else if (state_q == S_PUT) begin
			we = 1'b1;
			waddr = pos_q[IW-1:0];
			wdata = {item_q.dest_address, sum_q};
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						item_q <= in_data;
						sum_q <= in_data.kind == KIND_OWN ? '0 :
							(sum_w[COST_W] ? COST_MAX : sum_w[COST_W-1:0]);
						if (in_data.kind == KIND_DUMP) begin
							if (count_q == '0) begin
								out_q <= '{address: '0, cost: '0, found: 1'b0,
									status: ST_OK, last: 1'b1};
								out_valid_q <= 1'b1;
							end else begin
								state_q <= S_DUMP;
								idx_q <= CW'(1);
							end
						end else begin
							state_q <= S_SCAN;
							idx_q <= CW'(1);
						end
					end
				end
				S_SCAN: begin
					// rdata is entry idx_q-1
					if (below_w) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						pos_q <= prev_idx;
						if (hit_w) begin
							out_q.address <= item_q.dest_address;
							out_q.found <= 1'b1;
							out_q.last <= 1'b1;
							if (item_q.kind == KIND_QUERY) begin
								out_q.status <= ST_OK;
								out_q.cost <= r_cost < limit ? r_cost : noroute;
								state_q <= S_OUT;
							end else if (sum_q < r_cost) begin
								out_q.status <= ST_LOWERED;
								out_q.cost <= sum_q;
								state_q <= S_PUT;
							end else begin
								out_q.status <= ST_OK;
								out_q.cost <= r_cost;
								state_q <= S_OUT;
							end
						end else if (item_q.kind == KIND_QUERY) begin
							out_q <= '{address: item_q.dest_address, cost: noroute,
								found: 1'b0, status: ST_OK, last: 1'b1};
							state_q <= S_OUT;
						end else if (count_q == FULL) begin
							out_q <= '{address: item_q.dest_address, cost: '0,
								found: 1'b0, status: ST_FULL, last: 1'b1};
							state_q <= S_OUT;
						end else begin
							out_q <= '{address: item_q.dest_address, cost: sum_q,
								found: 1'b1, status: ST_INSERTED, last: 1'b1};
							count_q <= count_q + CW'(1);
							idx_q <= count_q;
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					// writes entry idx_q-1 into idx_q, reading next lower
					if (idx_q == pos_q) begin
						state_q <= S_PUT;
					end else begin
						idx_q <= idx_q - CW'(1);
					end
				end
				S_PUT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DUMP: begin
					if (out_load) begin
						out_q <= '{address: r_addr, cost: r_cost, found: 1'b1,
							status: ST_OK, last: idx_q == count_q};
						out_valid_q <= 1'b1;
						idx_q <= idx_q + CW'(1);
						if (idx_q == count_q) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* design/distance_vector_route_table_unit.sv */
// top level: route table with config registers
//
// channel | dir | carries
// in_ch   | in  | kind, dest_address, advertised_cost, link_cost
// out_ch  | out | address, cost, found, status, last
// cfg_ch  | in  | index, data (register write)
//
// one item at a time; lookup scans the ram one entry per cycle, and the next
// item is taken only after its result is accepted. an insert also shifts the
// entries above its place up and then places the new entry; a lowered cost
// is rewritten in place. a dump gives one word a cycle while the output is
// not stalled. reset clears the entry count; ram contents are not cleared.
// a stalled result holds the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module distance_vector_route_table_unit #(
	parameter int unsigned TABLE_DEPTH = dvrt_pkg::DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	dvrt_in_if.sink in_ch,
	dvrt_out_if.source out_ch,
	dvrt_cfg_if.sink cfg_ch
);
	import dvrt_pkg::*;
	logic [COST_W-1:0] limit_q;
	logic [COST_W-1:0] noroute_q;

	assign cfg_ch.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
			noroute_q <= NOROUTE_RST;
		end else if (cfg_ch.valid) begin
			if (cfg_ch.data.index == REG_LIMIT) begin
				limit_q <= cfg_ch.data.data;
			end else if (cfg_ch.data.index == REG_NOROUTE) begin
				noroute_q <= cfg_ch.data.data;
			end
		end
	end

	dvrt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.limit(limit_q), .noroute(noroute_q)
	);
endmodule
`default_nettype wire

/* design/dvrt_checker.sv */
// checker: port-level properties of the route table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module dvrt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [1:0] out_status,
	input wire logic out_found,
	input wire logic [15:0] out_cost
);
	import dvrt_pkg::*;
	// a result stalled stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	// no new item while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accepted during result");
	// a dropped insert is not found and has zero cost
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_FULL |-> !out_found && out_cost == '0)
		else $error("bad full result");
	// a result never appears the edge an item is taken
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid) else $error("overlap");
endmodule

bind distance_vector_route_table_unit dvrt_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_status(out_ch.data.status), .out_found(out_ch.data.found),
	.out_cost(out_ch.data.cost)
);
`default_nettype wire
